@@ hdl/iol_pkg.sv @@
package iol_pkg;

   // Defaults for the top-level parameters
   localparam int CAPACITY_DEF    = 64;
   localparam int VALUE_WIDTH_DEF = 32;

   // Fixed field widths on the ports
   localparam int KIND_W     = 3;
   localparam int POSITION_W = 7;
   localparam int ITEM_W     = 32;
   localparam int RESULT_W   = 32;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 7;

   // Operation kinds
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_MIN    = 3'd5;
   localparam logic [KIND_W-1:0] KIND_MAX    = 3'd6;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

   // Storage update applied by every cell
   localparam logic [1:0] MODE_HOLD   = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;
   localparam logic [1:0] MODE_WRITE  = 2'd3;

   // What a cell folds into the carrier passing through it
   localparam logic [1:0] PICK_NONE  = 2'd0;
   localparam logic [1:0] PICK_INDEX = 2'd1;
   localparam logic [1:0] PICK_MIN   = 2'd2;
   localparam logic [1:0] PICK_MAX   = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic [1:0] pick;
   } cell_ctl_type;

endpackage

@@ hdl/iol_cell.sv @@
module iol_cell import iol_pkg::*; #(
   parameter int CAPACITY    = CAPACITY_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int INDEX       = 0,
   localparam int CW         = $clog2(CAPACITY + 1)
) (
   input  logic                          clock,
   input  cell_ctl_type                  ctl,
   input  logic [CW-1:0]                 at,
   input  logic [CW-1:0]                 count,
   input  logic signed [VALUE_WIDTH-1:0] data,
   input  logic signed [VALUE_WIDTH-1:0] left_value,
   input  logic signed [VALUE_WIDTH-1:0] right_value,
   input  logic                          carry_have,
   input  logic signed [VALUE_WIDTH-1:0] carry_value,
   output logic signed [VALUE_WIDTH-1:0] value_out,
   output logic                          carry_have_out,
   output logic signed [VALUE_WIDTH-1:0] carry_value_out
);

   localparam logic [CW-1:0] IDX = CW'(INDEX);

   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;
   logic signed [VALUE_WIDTH-1:0] carry_value_ff, carry_value_in;
   logic                          carry_have_ff, carry_have_in;
   logic                          take;
   logic                          live;

   // Entry update: shift right on insert, left on remove, write in place at the index
   always_comb begin
      value_in = value_ff;
      case (ctl.mode)
         MODE_INSERT: begin
            if (IDX > at) begin
               value_in = left_value;
            end else if (IDX == at) begin
               value_in = data;
            end
         end
         MODE_REMOVE: begin
            if (IDX >= at) begin
               value_in = right_value;
            end
         end
         MODE_WRITE: begin
            if (IDX == at) begin
               value_in = data;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   // Carrier fold: select at an index, or keep the running min / max
   assign live = IDX < count;

   always_comb begin
      case (ctl.pick)
         PICK_INDEX: take = IDX == at;
         PICK_MIN:   take = live && (!carry_have || value_ff < carry_value);
         PICK_MAX:   take = live && (!carry_have || value_ff > carry_value);
         default:    take = 1'b0;
      endcase
      carry_have_in  = carry_have | take;
      carry_value_in = take ? value_ff : carry_value;
   end

   always_ff @(posedge clock) begin
      value_ff       <= value_in;
      carry_have_ff  <= carry_have_in;
      carry_value_ff <= carry_value_in;
   end

   assign value_out       = value_ff;
   assign carry_have_out  = carry_have_ff;
   assign carry_value_out = carry_value_ff;

endmodule

@@ hdl/indexed_ordered_list.sv @@
// Channel   | Ports                                        | Handshake
// ----------+----------------------------------------------+---------------------------------
// request   | req_kind, req_position, req_item_value       | start && !busy at a rising edge
// response  | rsp_result_value, rsp_status, rsp_entry_count| rsp_valid high for one cycle
//
// Insert, write, a flagged operation and the unused kind finish at the accept edge: the
// response strobes in the next cycle and busy stays low, so these run one per cycle.
// Remove, pop, read, minimum and maximum send a carrier down the row of cells, one cell
// per cycle: busy stays high while the carrier travels and the response strobes right after.
// Synchronous active-high reset empties the list; cell contents are left as they are.
// The receiver cannot stall: each response transaction is taken in its strobe cycle.
module indexed_ordered_list import iol_pkg::*; #(
   parameter int CAPACITY    = CAPACITY_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [KIND_W-1:0]          req_kind,
   input  logic [POSITION_W-1:0]      req_position,
   input  logic signed [ITEM_W-1:0]   req_item_value,
   output logic                       rsp_valid,
   output logic signed [RESULT_W-1:0] rsp_result_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [COUNT_W-1:0]         rsp_entry_count
);

   // Entry count and scan counter both need to hold CAPACITY itself
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CW > POSITION_W) ? CW : POSITION_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                    state_ff, state_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [RESULT_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;

   // Scan context, held steady while the carrier travels
   logic [CW-1:0]           at_ff, at_in;
   logic [1:0]              pick_ff, pick_in;
   logic                    shrink_ff, shrink_in;      // count drops at the end
   logic                    close_gap_ff, close_gap_in; // remove: shift left at the end

   // Broadcast to every cell
   cell_ctl_type                  ctl;
   logic [CW-1:0]                 bus_at;
   logic signed [VALUE_WIDTH-1:0] bus_data;

   logic signed [VALUE_WIDTH-1:0] value_w [CAPACITY];
   logic                          have_w  [CAPACITY+1];
   logic signed [VALUE_WIDTH-1:0] carry_w [CAPACITY+1];

   logic [CMP_W-1:0] pos_ext, count_ext;
   logic             in_range;
   logic             is_full;
   logic             is_empty;
   logic [CW-1:0]    at_req;

   // Request decode against the current length
   assign pos_ext   = CMP_W'(req_position);
   assign count_ext = CMP_W'(count_ff);
   assign in_range  = pos_ext < count_ext;
   assign at_req    = in_range ? CW'(pos_ext) : count_ff;   // past the end appends
   assign is_full   = count_ff == CW'(CAPACITY);
   assign is_empty  = count_ff == '0;
   assign bus_data  = VALUE_WIDTH'(req_item_value);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      at_in         = at_ff;
      pick_in       = pick_ff;
      shrink_in     = shrink_ff;
      close_gap_in  = close_gap_ff;
      ctl.mode      = MODE_HOLD;
      ctl.pick      = pick_ff;
      bus_at        = at_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // Default: answered right away with zero value
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = STATUS_OK;
               case (req_kind)
                  KIND_INSERT: begin
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        ctl.mode = MODE_INSERT;
                        bus_at   = at_req;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  KIND_WRITE: begin
                     if (!in_range) begin
                        rsp_status_in = STATUS_RANGE;
                     end else begin
                        ctl.mode = MODE_WRITE;
                        bus_at   = at_req;
                     end
                  end
                  KIND_REMOVE, KIND_READ: begin
                     if (!in_range) begin
                        rsp_status_in = STATUS_RANGE;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                        cnt_in       = '0;
                        at_in        = at_req;
                        pick_in      = PICK_INDEX;
                        shrink_in    = req_kind == KIND_REMOVE;
                        close_gap_in = req_kind == KIND_REMOVE;
                     end
                  end
                  KIND_POP: begin
                     if (is_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                        cnt_in       = '0;
                        at_in        = count_ff - 1'b1;
                        pick_in      = PICK_INDEX;
                        shrink_in    = 1'b1;
                        close_gap_in = 1'b0;
                     end
                  end
                  KIND_MIN, KIND_MAX: begin
                     if (is_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                        cnt_in       = '0;
                        pick_in      = (req_kind == KIND_MIN) ? PICK_MIN : PICK_MAX;
                        shrink_in    = 1'b0;
                        close_gap_in = 1'b0;
                     end
                  end
                  default: begin
                     // unused kind: no change, ok, zero
                     rsp_status_in = STATUS_OK;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (cnt_ff == CW'(CAPACITY)) begin
               // Carrier has left the last cell
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_value_in  = RESULT_W'(carry_w[CAPACITY]);
               if (shrink_ff) begin
                  count_in = count_ff - 1'b1;
               end
               if (close_gap_ff) begin
                  ctl.mode = MODE_REMOVE;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      at_ff         <= at_in;
      pick_ff       <= pick_in;
      shrink_ff     <= shrink_in;
      close_gap_ff  <= close_gap_in;
   end

   // Row of cells; the carrier enters cell 0 empty
   assign have_w[0]  = 1'b0;
   assign carry_w[0] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      iol_cell #(
         .CAPACITY    (CAPACITY),
         .VALUE_WIDTH (VALUE_WIDTH),
         .INDEX       (i)
      ) u_cell (
         .clock           (clock),
         .ctl             (ctl),
         .at              (bus_at),
         .count           (count_ff),
         .data            (bus_data),
         .left_value      ((i == 0) ? bus_data : value_w[(i == 0) ? 0 : i - 1]),
         .right_value     (value_w[(i == CAPACITY - 1) ? i : i + 1]),
         .carry_have      (have_w[i]),
         .carry_value     (carry_w[i]),
         .value_out       (value_w[i]),
         .carry_have_out  (have_w[i+1]),
         .carry_value_out (carry_w[i+1])
      );
   end

   assign busy             = state_ff == ST_SCAN;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = COUNT_W'(count_ff);

   // Length never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // Scan end gives exactly one response and frees the block
   a_scan_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && cnt_ff == CW'(CAPACITY)) |=>
         (rsp_valid && state_ff == ST_IDLE))
      else $error("scan end without response");

   // No response strobes while a scan is running
   a_scan_quiet: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("response during scan");

   // Accepted insert into a non-full list grows it by one
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == KIND_INSERT && !is_full) |=>
         (count_ff == CW'($past(count_ff) + 1'b1)))
      else $error("insert did not grow list");

   // Flagged responses carry a zero value
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> rsp_result_value == '0)
      else $error("flagged response with nonzero value");

endmodule

@@ tb/iol_checker.sv @@
module iol_checker import iol_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic [KIND_W-1:0]          req_kind,
   input  logic [POSITION_W-1:0]      req_position,
   input  logic signed [ITEM_W-1:0]   req_item_value,
   input  logic                       rsp_valid,
   input  logic signed [RESULT_W-1:0] rsp_result_value,
   input  logic [STATUS_W-1:0]        rsp_status,
   input  logic [COUNT_W-1:0]         rsp_entry_count,
   output int                         mismatch_count,
   output int                         outstanding
);

   typedef struct {
      logic [KIND_W-1:0]          kind;
      logic signed [RESULT_W-1:0] value;
      logic [STATUS_W-1:0]        status;
      logic [COUNT_W-1:0]         count;
   } list_reply_type;

   // shadow list, values held at full port width
   logic signed [ITEM_W-1:0] cells [CAPACITY];
   int                       occupancy;
   int                       errors;
   list_reply_type           reply_q [$];

   function automatic list_reply_type apply_op(input logic [KIND_W-1:0]        kind,
                                               input logic [POSITION_W-1:0]    pos,
                                               input logic signed [ITEM_W-1:0] val);
      list_reply_type r;
      int at;
      int idx;
      r.kind   = kind;
      r.value  = '0;
      r.status = STATUS_OK;
      at       = int'(pos);
      case (kind)
         KIND_INSERT: begin
            if (occupancy >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else begin
               if (at > occupancy) at = occupancy;
               for (idx = occupancy; idx > at; idx--) cells[idx] = cells[idx-1];
               cells[at] = val;
               occupancy++;
            end
         end
         KIND_REMOVE: begin
            if (at >= occupancy) begin
               r.status = STATUS_RANGE;
            end else begin
               r.value = cells[at];
               for (idx = at; idx + 1 < occupancy; idx++) cells[idx] = cells[idx+1];
               occupancy--;
            end
         end
         KIND_POP: begin
            if (occupancy == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.value = cells[occupancy-1];
               occupancy--;
            end
         end
         KIND_READ: begin
            if (at >= occupancy) r.status = STATUS_RANGE;
            else r.value = cells[at];
         end
         KIND_WRITE: begin
            if (at >= occupancy) r.status = STATUS_RANGE;
            else cells[at] = val;
         end
         KIND_MIN, KIND_MAX: begin
            if (occupancy == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.value = cells[0];
               for (idx = 1; idx < occupancy; idx++) begin
                  if ((kind == KIND_MIN && cells[idx] < r.value) ||
                      (kind == KIND_MAX && cells[idx] > r.value)) r.value = cells[idx];
               end
            end
         end
         default: ;
      endcase
      r.count = COUNT_W'(occupancy);
      return r;
   endfunction

   always @(posedge clock) begin
      list_reply_type want;
      if (reset) begin
         occupancy = 0;
         errors    = 0;
         reply_q.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (reply_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected transaction: value %0d status %0d count %0d",
                           rsp_result_value, rsp_status, rsp_entry_count);
            end else begin
               want = reply_q.pop_front();
               if (rsp_result_value !== want.value || rsp_status !== want.status ||
                   rsp_entry_count !== want.count) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch kind %0d: exp value %0d status %0d count %0d, got %0d %0d %0d",
                              want.kind, want.value, want.status, want.count,
                              rsp_result_value, rsp_status, rsp_entry_count);
               end
            end
         end
         if (start && !busy) reply_q.push_back(apply_op(req_kind, req_position, req_item_value));
      end
      mismatch_count <= errors;
      outstanding    <= reply_q.size();
   end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
   import iol_pkg::*;

   localparam int CAPACITY    = CAPACITY_DEF;
   localparam int RANDOM_OPS  = 850;
   // a long op holds busy for the whole scan; this bounds any drain wait
   localparam int DRAIN_LIMIT = 8 * CAPACITY + 200;
   // kind 7 has no operation behind it; the package leaves it unnamed
   localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

   typedef enum {PHASE_GROW, PHASE_SHRINK, PHASE_MIX} phase_type;

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       start          = 1'b0;
   logic [KIND_W-1:0]          req_kind       = KIND_INSERT;
   logic [POSITION_W-1:0]      req_position   = '0;
   logic signed [ITEM_W-1:0]   req_item_value = '0;
   logic                       busy;
   logic                       rsp_valid;
   logic signed [RESULT_W-1:0] rsp_result_value;
   logic [STATUS_W-1:0]        rsp_status;
   logic [COUNT_W-1:0]         rsp_entry_count;
   int                         mismatch_count;
   int                         outstanding;

   // stimulus-side estimate of the list length, only used to steer positions
   int fill;
   // when set, the sender issues back to back for the current stretch
   bit quiet;

   always #5 clock = ~clock;

   indexed_ordered_list dut (.*);

   iol_checker #(.CAPACITY(CAPACITY)) list_check (.*);

   // Safety net: the slowest legal run is far below this.
   initial begin
      #5_000_000;
      $display("FAIL indexed_ordered_list");
      $finish;
   end

   // Present one transaction and hold it until the block takes it. Called
   // right after a rising edge; returns right after the accepting edge.
   // busy is read before the block's own updates for that edge land.
   task automatic issue(input logic [KIND_W-1:0] kind, input int pos,
                        input logic signed [ITEM_W-1:0] val);
      start          <= 1'b1;
      req_kind       <= kind;
      req_position   <= POSITION_W'(pos);
      req_item_value <= val;
      do @(posedge clock); while (busy);
      case (kind)
         KIND_INSERT: if (fill < CAPACITY) fill++;
         KIND_REMOVE: if (pos < fill) fill--;
         KIND_POP:    if (fill > 0) fill--;
         default: ;
      endcase
   endtask

   // Drop start and sit until the checker holds no expectation. The
   // counter it reports is registered, hence the edge before the test.
   task automatic drain();
      int n;
      n = 0;
      start <= 1'b0;
      do begin
         @(posedge clock);
         n++;
      end while (outstanding != 0 && n < DRAIN_LIMIT);
   endtask

   // Idle between transactions: mostly none or short, now and then long.
   // At most one assignment to start per call, and none when there is no gap.
   task automatic rest();
      int r;
      int gap;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Extremes, small values and random words; the small ones make ties in min/max likely.
   function automatic logic signed [ITEM_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return '0;
         3:       return -1;
         4, 5:    return ITEM_W'($urandom_range(0, 7)) - 4;
         default: return $urandom;
      endcase
   endfunction

   // Mostly a live index, else the first dead one, else anywhere up to 127.
   function automatic int pick_position();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70 && fill > 0) return $urandom_range(0, fill - 1);
      if (r < 80) return fill;
      if (r < 90) return $urandom_range(fill, 127);
      return $urandom_range(0, 127);
   endfunction

   // Operation mix per phase; each row sums to 100, ordered by kind code.
   function automatic logic [KIND_W-1:0] pick_kind(input phase_type phase);
      int w [8];
      int r;
      int k;
      case (phase)
         PHASE_GROW:   w = '{70, 5, 3, 6, 6, 4, 4, 2};
         PHASE_SHRINK: w = '{8, 35, 25, 8, 8, 7, 7, 2};
         default:      w = '{20, 15, 10, 15, 15, 10, 10, 5};
      endcase
      r = $urandom_range(0, 99);
      for (k = 0; k < 7; k++) begin
         if (r < w[k]) return KIND_W'(k);
         r -= w[k];
      end
      return KIND_UNUSED;
   endfunction

   initial begin
      int        done;
      int        span;
      int        n;
      phase_type phase;
      logic [KIND_W-1:0] kind;

      fill  = 0;
      quiet = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // every access on an empty list: out-of-range and empty flags
      issue(KIND_REMOVE, 0, '0);                  rest();
      issue(KIND_POP, 0, '0);                     rest();
      issue(KIND_READ, 5, '0);                    rest();
      issue(KIND_WRITE, 0, 32'sh1234_5678);       rest();
      issue(KIND_MIN, 0, '0);                     rest();
      issue(KIND_MAX, 127, '0);                   rest();
      issue(KIND_UNUSED, 127, -1);                rest();
      // append from far past the end, push to front, insert in the middle,
      // insert exactly at the length, and a duplicate value for ties
      issue(KIND_INSERT, 127, 32'sh7FFF_FFFF);    rest();
      issue(KIND_INSERT, 0, 32'sh8000_0000);      rest();
      issue(KIND_INSERT, 1, -1);                  rest();
      issue(KIND_INSERT, 3, '0);                  rest();
      issue(KIND_INSERT, 2, -1);                  rest();
      // reads in range and just past the end, writes likewise
      issue(KIND_READ, 0, '0);                    rest();
      issue(KIND_READ, 4, '0);                    rest();
      issue(KIND_READ, 5, '0);                    rest();
      issue(KIND_WRITE, 1, 32'sh5555_5555);       rest();
      issue(KIND_WRITE, 5, 32'shAAAA_AAAA);       rest();
      issue(KIND_MIN, 0, '0);                     rest();
      issue(KIND_MAX, 0, '0);                     rest();
      // remove the front, the last, and past the end; then pop
      issue(KIND_REMOVE, 0, '0);                  rest();
      issue(KIND_REMOVE, 3, '0);                  rest();
      issue(KIND_REMOVE, 127, '0);                rest();
      issue(KIND_POP, 0, '0);                     rest();
      issue(KIND_UNUSED, 0, 32'sh8000_0000);
      // sender holds off until everything has come back
      drain();

      // ---- random part ----
      // Phases push the list toward full (where inserts get flagged) and back
      // to empty (where pops and lookups get flagged), with mixed stretches.
      done = 0;
      while (done < RANDOM_OPS) begin
         if (fill < 8) phase = ($urandom_range(0, 3) != 0) ? PHASE_GROW : PHASE_MIX;
         else if (fill >= CAPACITY - 4)
            phase = ($urandom_range(0, 3) != 0) ? PHASE_SHRINK : PHASE_MIX;
         else phase = phase_type'($urandom_range(0, 2));
         span  = $urandom_range(60, 140);
         quiet = ($urandom_range(0, 3) == 0);
         for (n = 0; n < span && done < RANDOM_OPS; n++) begin
            kind = pick_kind(phase);
            issue(kind, (kind == KIND_INSERT && $urandom_range(0, 4) == 0) ?
                        ($urandom_range(0, 1) ? 0 : fill) : pick_position(),
                  pick_value());
            if (kind != KIND_UNUSED) done++;
            if (n == span - 1 && $urandom_range(0, 3) == 0) drain();
            else if (done < RANDOM_OPS) rest();
         end
      end

      // ---- wrap-up ----
      drain();
      repeat (CAPACITY + 4) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("PASS indexed_ordered_list");
      end else begin
         $display("FAIL indexed_ordered_list");
      end
      $finish;
   end

endmodule
